FILE: sv/qvr_pkg.sv
package qvr_pkg;

  // Number of vector components handled per item.
  localparam int unsigned NUM_AXES = 3;

  // Register stages from an accepted input to a valid result.
  localparam int unsigned PIPE_DEPTH = 6;

  // Stage positions inside the pipeline.
  localparam int unsigned STG_PROD  = 0;
  localparam int unsigned STG_COEF  = 1;
  localparam int unsigned STG_PART  = 2;
  localparam int unsigned STG_TERM  = 3;
  localparam int unsigned STG_SUM   = 4;
  localparam int unsigned STG_OUT   = 5;

endpackage

FILE: sv/qvr_stream_if.sv
// Input channel: one quaternion and one vector per transfer.
interface qvr_in_if #(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [QUAT_WIDTH-1:0]  rot_x;
  logic signed [QUAT_WIDTH-1:0]  rot_y;
  logic signed [QUAT_WIDTH-1:0]  rot_z;
  logic signed [QUAT_WIDTH-1:0]  rot_w;
  logic signed [VEC_WIDTH-1:0]   vec_x;
  logic signed [VEC_WIDTH-1:0]   vec_y;
  logic signed [VEC_WIDTH-1:0]   vec_z;

  modport source (
    output valid, rot_x, rot_y, rot_z, rot_w, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, rot_w, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

// Output channel: one rotated vector per transfer.
interface qvr_out_if #(
  parameter int VEC_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] out_x;
  logic signed [VEC_WIDTH-1:0] out_y;
  logic signed [VEC_WIDTH-1:0] out_z;
  logic                        saturated;

  modport source (
    output valid, out_x, out_y, out_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, saturated,
    output ready
  );
endinterface

FILE: sv/quaternion_vector_rotate.sv
// Rotates a 3D vector by a quaternion: the result is the vector part of
// q * v * conj(q), computed in the equivalent matrix form with exact
// intermediates, rounded once to nearest (halves toward plus infinity) and
// saturated to the vector format, with saturated flagging any clipped
// component. The conjugate is used, so a non-unit quaternion also scales the
// vector by its squared norm. The datapath is a six-stage pipeline: quaternion
// products, rotation matrix coefficients, split coefficient-by-vector partial
// products, per-term recombination, row sums with the rounding offset, and
// the final shift and clip into the output register. An input transfer loads
// the product stage and its result moves through the stages in order to the
// output register. One item can be accepted on every clock unless the full
// pipeline is stalled. Each stage has its own valid bit and only holds when
// it is full and the stage after it cannot take its contents, so bubbles are
// squeezed out and the input stays ready while a finished result waits for
// the downstream side, until all six stages are full.
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst,
  qvr_in_if.sink    vin,
  qvr_out_if.source vout
);

  // Quaternion products and matrix coefficients. A coefficient such as
  // 2*(xy - wz) needs two bits more than a single product.
  localparam int PW = 2 * QUAT_WIDTH;
  localparam int CW = PW + 2;
  // The vector is split into an unsigned low half and a signed high half so
  // each multiplier stays narrow.
  localparam int VL = VEC_WIDTH / 2;
  localparam int VH = VEC_WIDTH - VL;
  localparam int LW = CW + VL + 1;
  localparam int HW = CW + VH;
  // Accumulator: a full term plus growth for three terms and the rounding.
  localparam int AW = CW + VEC_WIDTH + 3;
  // Both quaternion factors carry QUAT_WIDTH-2 fraction bits.
  localparam int RS = 2 * (QUAT_WIDTH - 2);

  localparam logic signed [AW-1:0] HALF_LSB = AW'(1) << (RS - 1);
  localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  // Handshake: a stage can load when it is empty or its contents move on.
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] rdy;

  always_comb begin
    rdy[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || vout.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vin.ready  = rdy[STG_PROD];
  assign vout.valid = vld[STG_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= vin.valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: the ten distinct quaternion products.
  logic signed [PW-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [VEC_WIDTH-1:0] vec1 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rdy[STG_PROD] && vin.valid) begin
      p_ww <= PW'(vin.rot_w) * PW'(vin.rot_w);
      p_xx <= PW'(vin.rot_x) * PW'(vin.rot_x);
      p_yy <= PW'(vin.rot_y) * PW'(vin.rot_y);
      p_zz <= PW'(vin.rot_z) * PW'(vin.rot_z);
      p_xy <= PW'(vin.rot_x) * PW'(vin.rot_y);
      p_xz <= PW'(vin.rot_x) * PW'(vin.rot_z);
      p_yz <= PW'(vin.rot_y) * PW'(vin.rot_z);
      p_wx <= PW'(vin.rot_w) * PW'(vin.rot_x);
      p_wy <= PW'(vin.rot_w) * PW'(vin.rot_y);
      p_wz <= PW'(vin.rot_w) * PW'(vin.rot_z);
      vec1[0] <= vin.vec_x;
      vec1[1] <= vin.vec_y;
      vec1[2] <= vin.vec_z;
    end
  end

  // Stage 2: the rotation matrix, row r multiplying the vector gives axis r.
  logic signed [CW-1:0] coef [NUM_AXES][NUM_AXES];
  logic signed [VEC_WIDTH-1:0] vec2 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rdy[STG_COEF] && vld[STG_PROD]) begin
      coef[0][0] <= CW'(p_ww) + CW'(p_xx) - CW'(p_yy) - CW'(p_zz);
      coef[1][1] <= CW'(p_ww) - CW'(p_xx) + CW'(p_yy) - CW'(p_zz);
      coef[2][2] <= CW'(p_ww) - CW'(p_xx) - CW'(p_yy) + CW'(p_zz);
      coef[0][1] <= (CW'(p_xy) - CW'(p_wz)) <<< 1;
      coef[0][2] <= (CW'(p_xz) + CW'(p_wy)) <<< 1;
      coef[1][0] <= (CW'(p_xy) + CW'(p_wz)) <<< 1;
      coef[1][2] <= (CW'(p_yz) - CW'(p_wx)) <<< 1;
      coef[2][0] <= (CW'(p_xz) - CW'(p_wy)) <<< 1;
      coef[2][1] <= (CW'(p_yz) + CW'(p_wx)) <<< 1;
      vec2 <= vec1;
    end
  end

  // Stage 3: each coefficient times the low and high halves of its
  // vector component.
  logic signed [LW-1:0] plo [NUM_AXES][NUM_AXES];
  logic signed [HW-1:0] phi [NUM_AXES][NUM_AXES];

  always_ff @(posedge clk) begin
    if (rdy[STG_PART] && vld[STG_COEF]) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          plo[r][c] <= LW'(coef[r][c]) * LW'($signed({1'b0, vec2[c][VL-1:0]}));
          phi[r][c] <= HW'(coef[r][c]) * HW'($signed(vec2[c][VEC_WIDTH-1:VL]));
        end
      end
    end
  end

  // Stage 4: recombine the halves into exact full products.
  logic signed [AW-1:0] term [NUM_AXES][NUM_AXES];

  always_ff @(posedge clk) begin
    if (rdy[STG_TERM] && vld[STG_PART]) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          term[r][c] <= (AW'(phi[r][c]) <<< VL) + AW'(plo[r][c]);
        end
      end
    end
  end

  // Stage 5: row sums with half an output LSB added for rounding.
  logic signed [AW-1:0] acc [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rdy[STG_SUM] && vld[STG_TERM]) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        acc[r] <= term[r][0] + term[r][1] + term[r][2] + HALF_LSB;
      end
    end
  end

  // Stage 6: drop the fraction bits and clip to the vector range.
  logic signed [AW-1:0]        shifted [NUM_AXES];
  logic signed [VEC_WIDTH-1:0] clipped [NUM_AXES];
  logic [NUM_AXES-1:0]         ovf;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      shifted[r] = acc[r] >>> RS;
      // In range only when the bits above the result's sign all match it.
      ovf[r] = !((&shifted[r][AW-1:VEC_WIDTH-1]) || !(|shifted[r][AW-1:VEC_WIDTH-1]));
      if (!ovf[r]) begin
        clipped[r] = shifted[r][VEC_WIDTH-1:0];
      end else if (shifted[r][AW-1]) begin
        clipped[r] = VMIN;
      end else begin
        clipped[r] = VMAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[STG_OUT] && vld[STG_SUM]) begin
      vout.out_x     <= clipped[0];
      vout.out_y     <= clipped[1];
      vout.out_z     <= clipped[2];
      vout.saturated <= |ovf;
    end
  end

endmodule

FILE: sv/qvr_checker.sv
module qvr_checker
  import qvr_pkg::*;
#(
  parameter int VEC_WIDTH = 32
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [VEC_WIDTH-1:0] out_x,
  input logic signed [VEC_WIDTH-1:0] out_y,
  input logic signed [VEC_WIDTH-1:0] out_z,
  input logic                        saturated
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);
  localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  // Items accepted whose results have not yet been transferred out.
  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(saturated))
    else $error("stalled result changed");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      out_x == VMAX || out_x == VMIN || out_y == VMAX || out_y == VMIN ||
      out_z == VMAX || out_z == VMIN)
    else $error("saturated flag without a clipped component");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result presented with no item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

endmodule

bind quaternion_vector_rotate qvr_checker #(
  .VEC_WIDTH(VEC_WIDTH)
) u_qvr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (vin.valid),
  .in_ready  (vin.ready),
  .out_valid (vout.valid),
  .out_ready (vout.ready),
  .out_x     (vout.out_x),
  .out_y     (vout.out_y),
  .out_z     (vout.out_z),
  .saturated (vout.saturated)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Testbench for quaternion_vector_rotate.
//
// Every input transfer is captured by a monitor, which runs the item through a
// local bit-exact model of the rotation and queues the expected rotated vector.
// The result side compares each output transfer, one field at a time, with the
// oldest queued expectation. The stimulus is a set of named tests run in turn:
// directed corner cases, a full-rate stream, a long output hold-off that backs
// up the pipeline, and a long random stream. The sender idles in bursts and the
// receiver stalls on a mode of its own, so bubbles land on every pipeline stage.
module tb;
  import qvr_pkg::*;

  localparam int QW     = 16;
  localparam int VW     = 32;
  localparam int QFRAC  = QW - 2;
  localparam int RSHIFT = 2 * QFRAC;

  // Cycles without any transfer before the run is declared hung. The longest
  // planned hold-off is well under this.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned MAX_PRINTS     = 40;

  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (RSHIFT - 1);
  localparam logic signed [127:0] VEC_MAX    = (128'sd1 <<< (VW - 1)) - 128'sd1;
  localparam logic signed [127:0] VEC_MIN    = -(128'sd1 <<< (VW - 1));

  // Handy raw encodings.
  localparam logic signed [QW-1:0] Q_ONE = 16'sd16384;   // 1.0 in Q1.14
  localparam logic signed [QW-1:0] Q_RT2 = 16'sd11585;   // about 1/sqrt(2)
  localparam logic signed [QW-1:0] Q_TOP = 16'sh7FFF;
  localparam logic signed [QW-1:0] Q_BOT = 16'sh8000;
  localparam logic signed [VW-1:0] V_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] V_BOT = 32'sh8000_0000;
  localparam logic signed [VW-1:0] V_ONE = 32'sh0001_0000; // 1.0 in Q15.16

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic signed [QW-1:0] rot_x;
    logic signed [QW-1:0] rot_y;
    logic signed [QW-1:0] rot_z;
    logic signed [QW-1:0] rot_w;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
  } rotation_req_t;

  typedef struct packed {
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic                 saturated;
  } rotated_vec_t;

  logic clk;
  logic rst;

  qvr_in_if  #(.QUAT_WIDTH(QW), .VEC_WIDTH(VW)) vin ();
  qvr_out_if #(.VEC_WIDTH(VW))                  vout ();

  quaternion_vector_rotate #(
    .QUAT_WIDTH(QW),
    .VEC_WIDTH (VW)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin),
    .vout (vout)
  );

  // Rotated vectors still owed by the block, oldest first.
  rotated_vec_t pending_rotations[$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  bit          sender_idles   = 1'b1;
  rx_mode_e    rx_mode        = RX_RANDOM;
  int unsigned hold_start     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Local model of the rotation. All products and sums are carried exactly in
  // 128 bits, so only the final rounding and clipping can lose information.
  // ---------------------------------------------------------------------------

  // Round to nearest with halves going toward plus infinity, then clip to the
  // vector format. Any clip raises the shared saturation flag.
  function automatic logic signed [VW-1:0] round_clip(input logic signed [127:0] acc,
                                                      inout logic clip);
    logic signed [127:0] scaled;
    scaled = (acc + ROUND_HALF) >>> RSHIFT;
    if (scaled > VEC_MAX) begin
      clip = 1'b1;
      return VW'(VEC_MAX);
    end
    if (scaled < VEC_MIN) begin
      clip = 1'b1;
      return VW'(VEC_MIN);
    end
    return VW'(scaled);
  endfunction

  // Vector part of q * v * conj(q) in its rotation-matrix form. The conjugate
  // is used, so a non-unit quaternion also scales by its squared norm.
  function automatic rotated_vec_t rotate_vector(input rotation_req_t r);
    logic signed [127:0] qx, qy, qz, qw, vx, vy, vz;
    logic signed [127:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    rotated_vec_t res;
    logic clip;
    qx = $signed(r.rot_x);
    qy = $signed(r.rot_y);
    qz = $signed(r.rot_z);
    qw = $signed(r.rot_w);
    vx = $signed(r.vec_x);
    vy = $signed(r.vec_y);
    vz = $signed(r.vec_z);
    m00 = qw * qw + qx * qx - qy * qy - qz * qz;
    m11 = qw * qw - qx * qx + qy * qy - qz * qz;
    m22 = qw * qw - qx * qx - qy * qy + qz * qz;
    m01 = (qx * qy - qw * qz) <<< 1;
    m02 = (qx * qz + qw * qy) <<< 1;
    m10 = (qx * qy + qw * qz) <<< 1;
    m12 = (qy * qz - qw * qx) <<< 1;
    m20 = (qx * qz - qw * qy) <<< 1;
    m21 = (qy * qz + qw * qx) <<< 1;
    clip = 1'b0;
    res.out_x = round_clip(m00 * vx + m01 * vy + m02 * vz, clip);
    res.out_y = round_clip(m10 * vx + m11 * vy + m12 * vz, clip);
    res.out_z = round_clip(m20 * vx + m21 * vy + m22 * vz, clip);
    res.saturated = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors and checking.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Every input transfer queues the result it should produce.
  always @(posedge clk) begin
    rotation_req_t seen;
    if (!rst && vin.valid && vin.ready) begin
      seen = '{vin.rot_x, vin.rot_y, vin.rot_z, vin.rot_w,
               vin.vec_x, vin.vec_y, vin.vec_z};
      pending_rotations.push_back(rotate_vector(seen));
    end
  end

  // Every output transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    rotated_vec_t want;
    if (!rst && vout.valid && vout.ready) begin
      if (pending_rotations.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d sat=%0b",
                                  vout.out_x, vout.out_y, vout.out_z, vout.saturated));
      end else begin
        want = pending_rotations.pop_front();
        if (vout.out_x !== want.out_x)
          report_mismatch($sformatf("out_x got %0d want %0d", vout.out_x, want.out_x));
        if (vout.out_y !== want.out_y)
          report_mismatch($sformatf("out_y got %0d want %0d", vout.out_y, want.out_y));
        if (vout.out_z !== want.out_z)
          report_mismatch($sformatf("out_z got %0d want %0d", vout.out_z, want.out_z));
        if (vout.saturated !== want.saturated)
          report_mismatch($sformatf("saturated got %0b want %0b",
                                    vout.saturated, want.saturated));
      end
    end
  end

  // Watchdog: too many cycles in a row with no transfer on either side means
  // the block has hung.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
          $display("timeout after %0d quiet cycles", quiet);
          $display("[quaternion_vector_rotate] ERROR");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side. A requested hold-off keeps ready low for a counted stretch;
  // otherwise ready follows the current stall mode.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned phase;
    hold_left = 0;
    phase = 0;
    vout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_start != 0) begin
        hold_left = hold_start;
        hold_start = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        vout.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: vout.ready <= 1'b1;
          RX_RANDOM: vout.ready <= ($urandom_range(0, 3) != 0);
          default:   vout.ready <= ((phase % 11) < 7);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic rotation_req_t make_req(input logic signed [QW-1:0] x,
                                             input logic signed [QW-1:0] y,
                                             input logic signed [QW-1:0] z,
                                             input logic signed [QW-1:0] w,
                                             input logic signed [VW-1:0] vx,
                                             input logic signed [VW-1:0] vy,
                                             input logic signed [VW-1:0] vz);
    return '{x, y, z, w, vx, vy, vz};
  endfunction

  // Offers one item and returns at the edge where it is transferred. When the
  // sender is idling, a new burst starts with a random gap. Valid is left high
  // so back-to-back items do not drop it between transfers.
  task automatic send_rotation(input rotation_req_t r);
    int unsigned gap;
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        vin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    vin.valid <= 1'b1;
    vin.rot_x <= r.rot_x;
    vin.rot_y <= r.rot_y;
    vin.rot_z <= r.rot_z;
    vin.rot_w <= r.rot_w;
    vin.vec_x <= r.vec_x;
    vin.vec_y <= r.vec_y;
    vin.vec_z <= r.vec_z;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every queued result has come back. The
  // first edge lets the monitor queue the item transferred at the current one.
  task automatic wait_for_results();
    vin.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_rotations.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [QW-1:0] corner_quat();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'sd1;
      2: return -16'sd1;
      3: return Q_ONE;
      4: return -Q_ONE;
      5: return Q_TOP;
      6: return Q_BOT;
      default: return Q_RT2;
    endcase
  endfunction

  function automatic logic signed [VW-1:0] corner_vec();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return V_ONE;
      4: return -V_ONE;
      5: return V_TOP;
      6: return V_BOT;
      default: return 32'sh0800_0000;
    endcase
  endfunction

  // A quaternion component of moderate size, so the norm stays near or under
  // one and most results land inside the vector range.
  function automatic logic signed [QW-1:0] moderate_quat();
    return QW'(int'($urandom_range(0, 23170)) - 11585);
  endfunction

  // A random vector component with a random number of top bits given up.
  function automatic logic signed [VW-1:0] shrunk_vec();
    logic signed [VW-1:0] raw;
    raw = $urandom;
    return raw >>> $urandom_range(0, 20);
  endfunction

  // Mix of raw bit patterns, moderate values, corner values and near-unit
  // quarter-turn rotations about the axes or the identity.
  function automatic rotation_req_t random_rotation();
    rotation_req_t r;
    logic signed [QW-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        r = make_req(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom),
                     $urandom, $urandom, $urandom);
      end
      3, 4, 5, 6: begin
        r = make_req(moderate_quat(), moderate_quat(), moderate_quat(), moderate_quat(),
                     shrunk_vec(), shrunk_vec(), shrunk_vec());
      end
      7, 8: begin
        r = make_req(corner_quat(), corner_quat(), corner_quat(), corner_quat(),
                     corner_vec(), corner_vec(), corner_vec());
      end
      default: begin
        s = $urandom_range(0, 1) ? Q_RT2 : -Q_RT2;
        case ($urandom_range(0, 3))
          0: r = make_req(s, '0, '0, Q_RT2, '0, '0, '0);
          1: r = make_req('0, s, '0, Q_RT2, '0, '0, '0);
          2: r = make_req('0, '0, s, Q_RT2, '0, '0, '0);
          default: r = make_req('0, '0, '0, Q_ONE, '0, '0, '0);
        endcase
        r.vec_x = shrunk_vec();
        r.vec_y = shrunk_vec();
        r.vec_z = shrunk_vec();
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Directed corners: identity and zero quaternions, axis rotations, extreme
  // components, the norm-squared scale at the edge of the vector range, and
  // rounding of exact halves.
  task automatic test_directed_corners();
    rx_mode = RX_RANDOM;
    sender_idles = 1'b1;
    // Identity leaves the vector alone, extremes included.
    send_rotation(make_req('0, '0, '0, Q_ONE, V_TOP, V_BOT, '0));
    send_rotation(make_req('0, '0, '0, Q_ONE, 32'sd1, -32'sd1, V_ONE));
    // Zero quaternion collapses everything to zero.
    send_rotation(make_req('0, '0, '0, '0, V_TOP, V_BOT, V_TOP));
    // Quarter turn about z, half turn about x and quarter turn about y.
    send_rotation(make_req('0, '0, Q_RT2, Q_RT2, V_ONE, '0, '0));
    send_rotation(make_req(Q_ONE, '0, '0, '0, V_ONE, 2 * V_ONE, 3 * V_ONE));
    send_rotation(make_req('0, -Q_RT2, '0, Q_RT2, '0, '0, -V_ONE));
    // Extreme quaternion components with extreme vectors drive saturation.
    send_rotation(make_req(Q_TOP, Q_TOP, Q_TOP, Q_TOP, V_TOP, V_TOP, V_TOP));
    send_rotation(make_req(Q_BOT, Q_BOT, Q_BOT, Q_BOT, V_BOT, V_BOT, V_BOT));
    send_rotation(make_req(Q_BOT, Q_TOP, '0, 16'sd1, V_TOP, V_BOT, V_ONE));
    send_rotation(make_req(Q_TOP, Q_BOT, Q_BOT, Q_TOP, V_BOT, V_TOP, V_BOT));
    // w at its most negative scales by exactly four: the first component just
    // fits, the second clips high, the third lands exactly on the lower bound.
    send_rotation(make_req('0, '0, '0, Q_BOT,
                           32'sh1FFF_FFFF, 32'sh2000_0000, -32'sh2000_0000));
    send_rotation(make_req('0, '0, '0, Q_BOT, -32'sh2000_0001, '0, '0));
    send_rotation(make_req('0, '0, '0, Q_TOP, 32'sh2000_0000, -32'sh2000_0000, '0));
    // With w at one LSB the result is the vector over 2^28, so these hit exact
    // halves: positive halves round up, negative halves round toward zero.
    send_rotation(make_req('0, '0, '0, 16'sd1,
                           32'sh0800_0000, -32'sh0800_0000, 32'sh1800_0000));
    send_rotation(make_req('0, '0, '0, 16'sd1,
                           -32'sh1800_0000, 32'sh07FF_FFFF, -32'sh0800_0001));
    send_rotation(make_req('0, '0, '0, -16'sd1, 32'sh0800_0000, V_TOP, V_BOT));
    // Non-unit quaternion with all terms active.
    send_rotation(make_req(16'sd3000, -16'sd7000, 16'sd12000, 16'sd20000,
                           -V_ONE, 5 * V_ONE, 32'sh0012_3456));
    send_rotation(make_req(16'sd1, 16'sd1, 16'sd1, 16'sd1, V_TOP, V_TOP, V_BOT));
    wait_for_results();
  endtask

  // Back-to-back items with the output always ready.
  task automatic test_full_rate();
    rx_mode = RX_ALWAYS;
    sender_idles = 1'b0;
    for (int i = 0; i < 80; i++) send_rotation(random_rotation());
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and the input stalls.
  task automatic test_backpressure_fill();
    rx_mode = RX_ALWAYS;
    sender_idles = 1'b0;
    hold_start = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_rotation(random_rotation());
    rx_mode = RX_PERIODIC;
    for (int i = 0; i < 30; i++) send_rotation(random_rotation());
    wait_for_results();
  endtask

  // Long random stream with both sides idling, a gap-free stretch, and one
  // pause until everything has drained.
  task automatic test_random_stream();
    for (int i = 0; i < 330; i++) begin
      if (i % 100 == 0) rx_mode = ((i / 100) % 2 == 0) ? RX_RANDOM : RX_PERIODIC;
      sender_idles = !(i >= 200 && i < 260);
      if (i == 300) wait_for_results();
      send_rotation(random_rotation());
    end
    wait_for_results();
  endtask

  initial begin
    rst       <= 1'b1;
    vin.valid <= 1'b0;
    vin.rot_x <= '0;
    vin.rot_y <= '0;
    vin.rot_z <= '0;
    vin.rot_w <= '0;
    vin.vec_x <= '0;
    vin.vec_y <= '0;
    vin.vec_z <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_full_rate();
    test_backpressure_fill();
    test_random_stream();

    // Let any stray result surface before the verdict.
    rx_mode = RX_ALWAYS;
    wait_for_results();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (pending_rotations.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_rotations.size()));

    if (mismatch_count == 0) begin
      $display("[quaternion_vector_rotate] OK");
    end else begin
      $display("[quaternion_vector_rotate] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/qvr_pkg.sv
sv/qvr_stream_if.sv
sv/quaternion_vector_rotate.sv
sv/qvr_checker.sv
tb/tb.sv
